// File: hdl/mctw_pkg.sv
// Shared types and constants for the multi-channel toggle watchdog.
package mctw_pkg;

  localparam int TICK_W    = 16;
  localparam int SUBCNT_W  = 6;
  localparam int PULSE_W   = 3;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  localparam logic [TICK_W-1:0]   TIMEOUT_RST = 16'd30;
  localparam logic [TICK_W-1:0]   WARNING_RST = 16'd15;
  localparam logic [TICK_W-1:0]   NOTIFY_RST  = 16'd10;
  localparam logic [SUBCNT_W-1:0] SPT_RST     = 6'd32;
  localparam logic [PULSE_W-1:0]  PULSE_RST   = 3'd4;

  localparam int FAST_BLINK_BIT = 0;
  localparam int SLOW_BLINK_BIT = 3;

  typedef enum logic [2:0] {
    REG_TIMEOUT = 3'd0,
    REG_WARNING = 3'd1,
    REG_NOTIFY  = 3'd2,
    REG_SPT     = 3'd3,
    REG_PULSE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0]   timeout_ticks;
    logic [TICK_W-1:0]   warning_ticks;
    logic [TICK_W-1:0]   notify_ticks;
    logic [SUBCNT_W-1:0] subticks_per_tick;
    logic [PULSE_W-1:0]  pulse_subticks;
  } cfg_t;

  typedef struct packed {
    logic                sub;
    logic [TICK_W-1:0]   tick;
    logic [SUBCNT_W-1:0] subcnt;
  } timebase_t;

endpackage

// File: hdl/mctw_prescaler.sv
// Sub-tick prescaler and wrapping main tick counter.
module mctw_prescaler
  import mctw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                sub,
  input  logic [SUBCNT_W-1:0] subticks_per_tick,
  output timebase_t           tb
);

  logic [TICK_W-1:0]   tick_count;
  logic [SUBCNT_W-1:0] subtick_count;
  logic [TICK_W-1:0]   tick_count_next;
  logic [SUBCNT_W-1:0] subtick_count_next;
  logic [SUBCNT_W-1:0] subcnt_inc;

  always_comb begin
    subcnt_inc         = subtick_count + SUBCNT_W'(1);
    tick_count_next    = tick_count;
    subtick_count_next = subtick_count;
    if (sub) begin
      if (subcnt_inc >= subticks_per_tick) begin
        tick_count_next    = tick_count + TICK_W'(1);
        subtick_count_next = '0;
      end else begin
        subtick_count_next = subcnt_inc;
      end
    end
  end

  assign tb.sub    = sub;
  assign tb.tick   = tick_count_next;
  assign tb.subcnt = subtick_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      subtick_count <= '0;
    end else if (step) begin
      tick_count    <= tick_count_next;
      subtick_count <= subtick_count_next;
    end
  end

endmodule

// File: hdl/mctw_channel.sv
// One watchdog channel: toggle detect, elapsed-time compare, relay pulse.
module mctw_channel
  import mctw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic      pin,
  input  timebase_t tb,
  input  cfg_t      cfg,
  output logic      led,
  output logic      relay
);

  logic [TICK_W-1:0]  last_kick;
  logic [PULSE_W-1:0] pulse_left;
  logic               previous_pin;
  logic [TICK_W-1:0]  last_kick_next;
  logic [PULSE_W-1:0] pulse_left_next;
  logic [PULSE_W-1:0] pulse_dec;
  logic [TICK_W-1:0]  elapsed;

  always_comb begin
    pulse_dec = pulse_left;
    if (tb.sub && (pulse_left != '0)) begin
      pulse_dec = pulse_left - PULSE_W'(1);
    end
    elapsed         = (pin != previous_pin) ? '0 : (tb.tick - last_kick);
    last_kick_next  = (pin != previous_pin) ? tb.tick : last_kick;
    pulse_left_next = pulse_dec;
    led             = 1'b0;
    relay           = 1'b0;
    if (pulse_dec != '0) begin
      led   = 1'b1;
      relay = 1'b1;
    end else if (elapsed > cfg.timeout_ticks) begin
      led             = 1'b1;
      relay           = 1'b1;
      last_kick_next  = tb.tick;
      pulse_left_next = cfg.pulse_subticks;
    end else if (elapsed > cfg.warning_ticks) begin
      led = tb.subcnt[FAST_BLINK_BIT];
    end else if (elapsed > cfg.notify_ticks) begin
      led = tb.subcnt[SLOW_BLINK_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_kick    <= '0;
      pulse_left   <= '0;
      previous_pin <= 1'b0;
    end else if (step) begin
      last_kick    <= last_kick_next;
      pulse_left   <= pulse_left_next;
      previous_pin <= pin;
    end
  end

endmodule

// File: hdl/multi_channel_toggle_watchdog_unit.sv
// An accepted input transaction is held in the input register; a combinational evaluation
//   of all channels in parallel loads its result into the result register on the outputs.
// Throughput: one transaction per cycle while the result register is empty or taken.
// The input side stalls only while the result register is full and not taken.
// Reset (synchronous, active high) clears counters, channel state and valids,
//   and loads the register defaults 30/15/10/32/4.
module multi_channel_toggle_watchdog_unit
  import mctw_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    subtick,
  input  logic [NUM_CHANNELS-1:0] kick_pins,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [NUM_CHANNELS-1:0] led_bits,
  output logic [NUM_CHANNELS-1:0] relay_bits
);

  cfg_t                    cfg;
  timebase_t               tb;
  logic                    s1_valid;
  logic                    s1_sub;
  logic [NUM_CHANNELS-1:0] s1_pins;
  logic                    advance;
  logic                    step;
  logic [NUM_CHANNELS-1:0] led_next;
  logic [NUM_CHANNELS-1:0] relay_next;
  reg_idx_t                reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks     <= TIMEOUT_RST;
      cfg.warning_ticks     <= WARNING_RST;
      cfg.notify_ticks      <= NOTIFY_RST;
      cfg.subticks_per_tick <= SPT_RST;
      cfg.pulse_subticks    <= PULSE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_TIMEOUT: cfg.timeout_ticks     <= pwdata[TICK_W-1:0];
        REG_WARNING: cfg.warning_ticks     <= pwdata[TICK_W-1:0];
        REG_NOTIFY:  cfg.notify_ticks      <= pwdata[TICK_W-1:0];
        REG_SPT:     cfg.subticks_per_tick <= pwdata[SUBCNT_W-1:0];
        REG_PULSE:   cfg.pulse_subticks    <= pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TIMEOUT: prdata = APB_DW'(cfg.timeout_ticks);
      REG_WARNING: prdata = APB_DW'(cfg.warning_ticks);
      REG_NOTIFY:  prdata = APB_DW'(cfg.notify_ticks);
      REG_SPT:     prdata = APB_DW'(cfg.subticks_per_tick);
      REG_PULSE:   prdata = APB_DW'(cfg.pulse_subticks);
      default:     prdata = '0;
    endcase
  end

  assign advance  = !out_valid || out_ready;
  assign step     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sub  <= subtick;
      s1_pins <= kick_pins;
    end
  end

  mctw_prescaler u_prescaler (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .sub               (s1_sub),
    .subticks_per_tick (cfg.subticks_per_tick),
    .tb                (tb)
  );

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
    mctw_channel u_channel (
      .clk   (clk),
      .rst   (rst),
      .step  (step),
      .pin   (s1_pins[g]),
      .tb    (tb),
      .cfg   (cfg),
      .led   (led_next[g]),
      .relay (relay_next[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      led_bits   <= led_next;
      relay_bits <= relay_next;
    end
  end

  a_relay_lights_led: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((relay_bits & ~led_bits) == '0))
    else $error("relay driven with LED off");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(u_prescaler.tick_count))
    else $error("tick counter moved without a transaction");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(led_bits) && $stable(relay_bits))
    else $error("result changed while stalled");

endmodule

// File: sim/watchdog_monitor.sv
// Channel monitor for the toggle watchdog: predicts each result and compares it.
module watchdog_monitor
  import mctw_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    subtick,
  input  logic [NUM_CHANNELS-1:0] kick_pins,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [NUM_CHANNELS-1:0] led_bits,
  input  logic [NUM_CHANNELS-1:0] relay_bits,
  output int                      lamps_pending,
  output int                      fail_count
);

  typedef struct packed {
    logic [NUM_CHANNELS-1:0] led;
    logic [NUM_CHANNELS-1:0] relay;
  } lamp_state_t;

  cfg_t                limits;
  logic [TICK_W-1:0]   tick_cnt;
  logic [SUBCNT_W-1:0] sub_cnt;
  logic [TICK_W-1:0]   last_kick [NUM_CHANNELS];
  logic [PULSE_W-1:0]  pulse_left [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] prev_pins;

  lamp_state_t lamps_due [$];
  int          mismatch_cnt = 0;
  int          result_idx = 0;

  assign fail_count = mismatch_cnt;

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 100) begin
      $display("mismatch at result %0d: %s", result_idx, msg);
    end
    mismatch_cnt++;
  endtask

  task automatic advance_watchdog(input logic sub, input logic [NUM_CHANNELS-1:0] pins,
                                  output lamp_state_t lamps);
    logic [NUM_CHANNELS-1:0] toggled;
    logic [TICK_W-1:0]       elapsed;
    lamps = '0;
    if (sub) begin
      sub_cnt = sub_cnt + 1'b1;
      if (sub_cnt >= limits.subticks_per_tick) begin
        tick_cnt = tick_cnt + 1'b1;
        sub_cnt  = '0;
      end
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        if (pulse_left[ch] != '0) pulse_left[ch] = pulse_left[ch] - 1'b1;
      end
    end
    toggled = pins ^ prev_pins;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      if (toggled[ch]) last_kick[ch] = tick_cnt;
    end
    prev_pins = pins;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      if (pulse_left[ch] != '0) begin
        lamps.led[ch]   = 1'b1;
        lamps.relay[ch] = 1'b1;
      end else begin
        elapsed = tick_cnt - last_kick[ch];
        if (elapsed > limits.timeout_ticks) begin
          lamps.led[ch]   = 1'b1;
          lamps.relay[ch] = 1'b1;
          last_kick[ch]   = tick_cnt;
          pulse_left[ch]  = limits.pulse_subticks;
        end else if (elapsed > limits.warning_ticks) begin
          lamps.led[ch] = sub_cnt[FAST_BLINK_BIT];
        end else if (elapsed > limits.notify_ticks) begin
          lamps.led[ch] = sub_cnt[SLOW_BLINK_BIT];
        end
      end
    end
  endtask

  always @(posedge clk) begin
    lamp_state_t lamps;
    if (rst) begin
      limits.timeout_ticks     = TIMEOUT_RST;
      limits.warning_ticks     = WARNING_RST;
      limits.notify_ticks      = NOTIFY_RST;
      limits.subticks_per_tick = SPT_RST;
      limits.pulse_subticks    = PULSE_RST;
      tick_cnt  = '0;
      sub_cnt   = '0;
      prev_pins = '0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        last_kick[ch]  = '0;
        pulse_left[ch] = '0;
      end
      lamps_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_TIMEOUT: limits.timeout_ticks     = pwdata[TICK_W-1:0];
          REG_WARNING: limits.warning_ticks     = pwdata[TICK_W-1:0];
          REG_NOTIFY:  limits.notify_ticks      = pwdata[TICK_W-1:0];
          REG_SPT:     limits.subticks_per_tick = pwdata[SUBCNT_W-1:0];
          REG_PULSE:   limits.pulse_subticks    = pwdata[PULSE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (lamps_due.size() == 0) begin
          report_mismatch($sformatf("led=%h relay=%h with no transaction pending",
                                    led_bits, relay_bits));
        end else begin
          lamps = lamps_due.pop_front();
          if (led_bits !== lamps.led)
            report_mismatch($sformatf("led_bits %h, want %h", led_bits, lamps.led));
          if (relay_bits !== lamps.relay)
            report_mismatch($sformatf("relay_bits %h, want %h", relay_bits, lamps.relay));
        end
        result_idx++;
      end
      if (in_valid && in_ready) begin
        advance_watchdog(subtick, kick_pins, lamps);
        lamps_due.push_back(lamps);
      end
    end
    lamps_pending <= lamps_due.size();
  end

endmodule

// File: sim/tb.sv
// Testbench top for the toggle watchdog: clock, reset, stimulus and verdict.
module tb
  import mctw_pkg::*;
();

  localparam int NCH = 4;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              subtick = 1'b0;
  logic [NCH-1:0]    kick_pins = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [NCH-1:0]    led_bits;
  logic [NCH-1:0]    relay_bits;

  int lamps_pending;
  int fail_count;
  int burst_left = 0;
  int rcv_cycle = 0;
  int cycle_cnt = 0;

  multi_channel_toggle_watchdog_unit #(.NUM_CHANNELS(NCH)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .subtick(subtick), .kick_pins(kick_pins),
    .out_valid(out_valid), .out_ready(out_ready),
    .led_bits(led_bits), .relay_bits(relay_bits)
  );

  watchdog_monitor #(.NUM_CHANNELS(NCH)) u_monitor (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .subtick(subtick), .kick_pins(kick_pins),
    .out_valid(out_valid), .out_ready(out_ready),
    .led_bits(led_bits), .relay_bits(relay_bits),
    .lamps_pending(lamps_pending), .fail_count(fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    rcv_cycle <= rcv_cycle + 1;
    case (rcv_cycle[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
      2'd2:    out_ready <= (rcv_cycle[4:2] != 3'd0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_config(input logic [TICK_W-1:0] timeout_val,
                              input logic [TICK_W-1:0] warning_val,
                              input logic [TICK_W-1:0] notify_val,
                              input logic [SUBCNT_W-1:0] spt_val,
                              input logic [PULSE_W-1:0] pulse_val);
    logic [APB_DW-1:0] vals [5];
    vals = '{APB_DW'(timeout_val), APB_DW'(warning_val), APB_DW'(notify_val),
             APB_DW'(spt_val), APB_DW'(pulse_val)};
    pwrite <= 1'b1;
    for (int r = 0; r < 5; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      paddr   <= {reg_idx_t'(r), 2'b00};
      pwdata  <= vals[r];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_sample(input logic sub, input logic [NCH-1:0] pins);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid  <= 1'b1;
    subtick   <= sub;
    kick_pins <= pins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lamps_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [NCH-1:0]      pins;
    logic [TICK_W-1:0]   t_val, w_val, n_val;
    logic [SUBCNT_W-1:0] spt_val;
    logic [PULSE_W-1:0]  pulse_val;
    int                  sub_pct;
    int                  kick_pct [NCH];

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_sample(1'b0, 4'h0);
    send_sample(1'b1, 4'hF);
    send_sample(1'b1, 4'h0);
    send_sample(1'b0, 4'h5);
    send_sample(1'b1, 4'hA);
    drain();

    // walk the starved channels through notify, warning, timeout and pulse
    write_config(16'd3, 16'd2, 16'd1, 6'd1, 3'd2);
    pins = 4'hA;
    for (int i = 0; i < 18; i++) begin
      pins[0] = ~pins[0];
      send_sample(1'b1, pins);
    end
    drain();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin t_val = 8;      w_val = 5;      n_val = 2;      spt_val = 1;  pulse_val = 1; end
        1: begin t_val = 6;      w_val = 4;      n_val = 2;      spt_val = 2;  pulse_val = 7; end
        2: begin t_val = 4;      w_val = 2;      n_val = 1;      spt_val = 0;  pulse_val = 0; end
        3: begin t_val = 1;      w_val = 0;      n_val = 0;      spt_val = 32; pulse_val = 3; end
        4: begin t_val = 3;      w_val = 2;      n_val = 1;      spt_val = 3;  pulse_val = 5; end
        5: begin t_val = 16'hFFFF; w_val = 16'hFFFF; n_val = 16'hFFFF; spt_val = 1; pulse_val = 7; end
        6: begin t_val = 0;      w_val = 0;      n_val = 0;      spt_val = 1;  pulse_val = 1; end
        7: begin t_val = 5;      w_val = 3;      n_val = 1;      spt_val = 16; pulse_val = 4; end
        default: begin
          t_val     = TICK_W'($urandom_range(0, 10));
          w_val     = TICK_W'($urandom_range(0, 10));
          n_val     = TICK_W'($urandom_range(0, 10));
          spt_val   = SUBCNT_W'($urandom_range(0, 12));
          pulse_val = PULSE_W'($urandom_range(0, 7));
        end
      endcase
      write_config(t_val, w_val, n_val, spt_val, pulse_val);
      sub_pct = $urandom_range(25, 100);
      for (int ch = 0; ch < NCH; ch++) begin
        case ($urandom_range(0, 3))
          0:       kick_pct[ch] = 0;
          1:       kick_pct[ch] = 3;
          2:       kick_pct[ch] = 25;
          default: kick_pct[ch] = 90;
        endcase
      end
      for (int i = 0; i < 130; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          pins = NCH'($urandom);
        end else begin
          for (int ch = 0; ch < NCH; ch++) begin
            if ($urandom_range(1, 100) <= kick_pct[ch]) pins[ch] = ~pins[ch];
          end
        end
        send_sample($urandom_range(1, 100) <= sub_pct, pins);
        if (p == 2 && i == 60) drain();
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
